// ===== rtl/rsfc_pkg.sv =====
package rsfc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] count16_type;
   typedef logic [31:0] word_type;

   // header is RIFF tag, 4-byte size, 4-byte form tag
   localparam int HDR_LEN = 12;
   localparam int TAG_LEN = 4;
   localparam int REM_W   = $clog2(HDR_LEN + 1);

   typedef logic [REM_W-1:0] rem_type;

   // tags as they appear in the stream, first byte in the top bits
   localparam word_type SIG_RIFF = 32'h5249_4646;
   localparam word_type SIG_WAVE = 32'h5741_5645;
   localparam word_type SIG_WEBP = 32'h5745_4250;
   localparam word_type SIG_DATA = 32'h6461_7461;

   localparam logic FMT_WAV  = 1'b0;
   localparam logic FMT_WEBP = 1'b1;

   localparam word_type WEBP_MIN_SIZE = 32'd4;
   localparam count16_type FILES_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_SCAN = 2'd0,
      PH_SEEK = 2'd1,
      PH_SIZE = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

endpackage

// ===== rtl/rsfc_intf.sv =====
interface rsfc_req_if;
   logic                valid;
   logic                ready;
   rsfc_pkg::byte_type  stream_byte;
   logic                end_of_stream;

   modport source (output valid, output stream_byte, output end_of_stream, input ready);
   modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface rsfc_rsp_if;
   logic                   valid;
   logic                   ready;
   rsfc_pkg::byte_type     out_byte;
   rsfc_pkg::count16_type  file_number;
   logic                   file_start;
   logic                   file_end;
   logic                   truncated;
   rsfc_pkg::word_type     declared_size;
   logic                   run_last;

   modport source (output valid, output out_byte, output file_number, output file_start,
                   output file_end, output truncated, output declared_size,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input file_number, input file_start,
                   input file_end, input truncated, input declared_size,
                   input run_last, output ready);
endinterface

// ===== rtl/riff_signature_file_carver.sv =====
// Channel | Dir | Payload                                              | Handshake
// req     | in  | stream_byte[8], end_of_stream                        | valid/ready
// rsp     | out | out_byte[8], file_number[16], file_start, file_end,  | valid/ready
//         |     | truncated, declared_size[32], run_last               |
// csr     | in  | csr_write_data = format_select (0 WAV, 1 WebP)       | csr_write_enable
//
// Cycles: one byte per cycle while scanning or inside a file, as long as rsp is ready; a header
// match loads the 12 header bytes into the output buffer, which drains one beat per cycle, so
// req holds low after a header until the last header beat leaves.
// Reset: synchronous, active high; clears windows, phase, counters, rsp valid.
// Stalls: req is ready when the buffer is empty or its last beat leaves this cycle;
// any held rsp beat holds off req.
module riff_signature_file_carver (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   rsfc_req_if.sink  req,
   rsfc_rsp_if.source rsp
);

   localparam int HL = rsfc_pkg::HDR_LEN;
   localparam int TL = rsfc_pkg::TAG_LEN;

   // carve state
   logic                    format_ff;
   rsfc_pkg::byte_type      hw_ff [HL];
   rsfc_pkg::byte_type      hw_in [HL];
   rsfc_pkg::byte_type      tag_ff [TL];
   rsfc_pkg::byte_type      tag_in [TL];
   rsfc_pkg::phase_type     phase_ff, phase_in;
   rsfc_pkg::word_type      left_ff, left_in;
   rsfc_pkg::word_type      asm_ff, asm_in;
   logic [1:0]              sbi_ff, sbi_in;
   rsfc_pkg::count16_type   found_ff, found_in;

   // output shift buffer: header bursts fill all entries, single beats sit in entry 0
   rsfc_pkg::byte_type      ob_ff [HL];
   rsfc_pkg::byte_type      ob_in [HL];
   rsfc_pkg::rem_type       rem_ff, rem_in;
   logic                    ov_ff, ov_in;
   logic                    hdr_ff, hdr_in;
   logic                    oend_ff, oend_in;
   logic                    otrunc_ff, otrunc_in;
   rsfc_pkg::count16_type   onum_ff, onum_in;
   rsfc_pkg::word_type      odecl_ff, odecl_in;

   // per-beat decode
   rsfc_pkg::byte_type      b;
   rsfc_pkg::byte_type      win [HL];
   rsfc_pkg::byte_type      tag_sh [TL];
   rsfc_pkg::word_type      form_tag;
   rsfc_pkg::word_type      sz_hdr;
   rsfc_pkg::word_type      asm_new;
   rsfc_pkg::word_type      left_dec;
   rsfc_pkg::word_type      decl_c;
   logic                    hdr_match;
   logic                    emit_one, emit_hdr;
   logic                    end_c, trunc_c;
   logic                    accept, take, last_beat;

   assign b         = req.stream_byte;
   assign last_beat = (rem_ff == rsfc_pkg::rem_type'(1));
   assign take      = ov_ff && rsp.ready;
   assign req.ready = !ov_ff || (rsp.ready && last_beat);
   assign accept    = req.valid && req.ready;

   // window as it stands once this byte has shifted in
   always_comb begin
      for (int i = 0; i < HL - 1; i++) begin
         win[i] = hw_ff[i + 1];
      end
      win[HL - 1] = b;
      for (int i = 0; i < TL - 1; i++) begin
         tag_sh[i] = tag_ff[i + 1];
      end
      tag_sh[TL - 1] = b;
   end

   assign form_tag  = (format_ff == rsfc_pkg::FMT_WEBP) ? rsfc_pkg::SIG_WEBP
                                                        : rsfc_pkg::SIG_WAVE;
   assign hdr_match = ({win[0], win[1], win[2], win[3]} == rsfc_pkg::SIG_RIFF) &&
                      ({win[8], win[9], win[10], win[11]} == form_tag);
   // size fields are little endian
   assign sz_hdr    = {win[7], win[6], win[5], win[4]};
   assign asm_new   = asm_ff | ({24'd0, b} << {sbi_ff, 3'b000});
   assign left_dec  = left_ff - 32'd1;

   // next carve state and result of this beat
   always_comb begin
      hw_in    = hw_ff;
      tag_in   = tag_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      asm_in   = asm_ff;
      sbi_in   = sbi_ff;
      found_in = found_ff;
      emit_one = 1'b0;
      emit_hdr = 1'b0;
      end_c    = 1'b0;
      decl_c   = '0;

      unique case (phase_ff)
         rsfc_pkg::PH_SCAN: begin
            hw_in = win;
            if (hdr_match) begin
               emit_hdr = 1'b1;
               if (found_ff != rsfc_pkg::FILES_MAX) begin
                  found_in = found_ff + 16'd1;
               end
               // windows restart empty for the new file
               for (int i = 0; i < HL; i++) hw_in[i] = '0;
               for (int i = 0; i < TL; i++) tag_in[i] = '0;
               left_in = '0;
               asm_in  = '0;
               sbi_in  = '0;
               if (format_ff == rsfc_pkg::FMT_WEBP) begin
                  decl_c = sz_hdr;
                  if (sz_hdr <= rsfc_pkg::WEBP_MIN_SIZE) begin
                     // nothing past the header: file ends on its last byte
                     end_c    = 1'b1;
                     phase_in = rsfc_pkg::PH_SCAN;
                  end else begin
                     asm_in   = sz_hdr;
                     left_in  = sz_hdr - rsfc_pkg::WEBP_MIN_SIZE;
                     phase_in = rsfc_pkg::PH_BODY;
                  end
               end else begin
                  phase_in = rsfc_pkg::PH_SEEK;
               end
            end
         end
         rsfc_pkg::PH_SEEK: begin
            emit_one = 1'b1;
            tag_in   = tag_sh;
            if ({tag_sh[0], tag_sh[1], tag_sh[2], tag_sh[3]} == rsfc_pkg::SIG_DATA) begin
               phase_in = rsfc_pkg::PH_SIZE;
               sbi_in   = '0;
               asm_in   = '0;
            end
         end
         rsfc_pkg::PH_SIZE: begin
            emit_one = 1'b1;
            asm_in   = asm_new;
            if (sbi_ff == 2'd3) begin
               decl_c = asm_new;
               if (asm_new == '0) begin
                  end_c = 1'b1;
                  for (int i = 0; i < HL; i++) hw_in[i] = '0;
                  for (int i = 0; i < TL; i++) tag_in[i] = '0;
                  phase_in = rsfc_pkg::PH_SCAN;
                  left_in  = '0;
                  asm_in   = '0;
                  sbi_in   = '0;
               end else begin
                  left_in  = asm_new;
                  sbi_in   = '0;
                  phase_in = rsfc_pkg::PH_BODY;
               end
            end else begin
               sbi_in = sbi_ff + 2'd1;
            end
         end
         rsfc_pkg::PH_BODY: begin
            emit_one = 1'b1;
            decl_c   = asm_ff;
            left_in  = left_dec;
            if (left_dec == '0) begin
               end_c = 1'b1;
               for (int i = 0; i < HL; i++) hw_in[i] = '0;
               for (int i = 0; i < TL; i++) tag_in[i] = '0;
               phase_in = rsfc_pkg::PH_SCAN;
               asm_in   = '0;
               sbi_in   = '0;
            end
         end
         default: begin
            phase_in = rsfc_pkg::PH_SCAN;
         end
      endcase

      // end of stream inside a file cuts it short
      trunc_c = req.end_of_stream && (emit_one || emit_hdr) &&
                (phase_in != rsfc_pkg::PH_SCAN);

      // drop everything but the file count on end of stream
      if (req.end_of_stream) begin
         for (int i = 0; i < HL; i++) hw_in[i] = '0;
         for (int i = 0; i < TL; i++) tag_in[i] = '0;
         phase_in = rsfc_pkg::PH_SCAN;
         left_in  = '0;
         asm_in   = '0;
         sbi_in   = '0;
      end
   end

   // output buffer: shift one beat out per take, reload on an accepted byte with results
   always_comb begin
      ob_in     = ob_ff;
      rem_in    = rem_ff;
      ov_in     = ov_ff;
      hdr_in    = hdr_ff;
      oend_in   = oend_ff;
      otrunc_in = otrunc_ff;
      onum_in   = onum_ff;
      odecl_in  = odecl_ff;

      if (take) begin
         if (last_beat) begin
            ov_in = 1'b0;
         end else begin
            for (int i = 0; i < HL - 1; i++) begin
               ob_in[i] = ob_ff[i + 1];
            end
            rem_in = rem_ff - rsfc_pkg::rem_type'(1);
         end
      end

      if (accept && (emit_one || emit_hdr)) begin
         ov_in     = 1'b1;
         hdr_in    = emit_hdr;
         oend_in   = end_c || trunc_c;
         otrunc_in = trunc_c;
         onum_in   = found_in;
         odecl_in  = decl_c;
         if (emit_hdr) begin
            ob_in  = win;
            rem_in = rsfc_pkg::rem_type'(HL);
         end else begin
            ob_in[0] = b;
            rem_in   = rsfc_pkg::rem_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= rsfc_pkg::FMT_WAV;
      end else if (csr_write_enable) begin
         format_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HL; i++) hw_ff[i] <= '0;
         for (int i = 0; i < TL; i++) tag_ff[i] <= '0;
         phase_ff <= rsfc_pkg::PH_SCAN;
         left_ff  <= '0;
         asm_ff   <= '0;
         sbi_ff   <= '0;
         found_ff <= '0;
      end else if (accept) begin
         hw_ff    <= hw_in;
         tag_ff   <= tag_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         asm_ff   <= asm_in;
         sbi_ff   <= sbi_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff  <= 1'b0;
         rem_ff <= '0;
      end else begin
         ov_ff  <= ov_in;
         rem_ff <= rem_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      ob_ff     <= ob_in;
      hdr_ff    <= hdr_in;
      oend_ff   <= oend_in;
      otrunc_ff <= otrunc_in;
      onum_ff   <= onum_in;
      odecl_ff  <= odecl_in;
   end

   assign rsp.valid         = ov_ff;
   assign rsp.out_byte      = ob_ff[0];
   assign rsp.file_number   = onum_ff;
   assign rsp.file_start    = hdr_ff && (rem_ff == rsfc_pkg::rem_type'(HL));
   assign rsp.file_end      = oend_ff && last_beat;
   assign rsp.truncated     = otrunc_ff && last_beat;
   assign rsp.declared_size = odecl_ff;
   assign rsp.run_last      = last_beat;

endmodule

// ===== rtl/rsfc_checker.sv =====
module rsfc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsfc_pkg::byte_type     rsp_out_byte,
   input rsfc_pkg::count16_type  rsp_file_number,
   input logic                   rsp_file_start,
   input logic                   rsp_file_end,
   input logic                   rsp_truncated,
   input rsfc_pkg::word_type     rsp_declared_size,
   input logic                   rsp_run_last
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_file_number) && $stable(rsp_declared_size) && $stable(rsp_run_last))
      else $error("rsp beat changed while stalled");

   // reset empties the output side
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a stalled output blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req ready while rsp stalled");

   // truncation only closes a run
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_file_end && rsp_run_last)
      else $error("truncated without file end on last beat");

   // a file start is always counted
   a_start_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_file_start |-> rsp_file_number != 16'd0)
      else $error("file start with zero file number");

endmodule

bind riff_signature_file_carver rsfc_checker u_rsfc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_byte      (rsp.out_byte),
   .rsp_file_number   (rsp.file_number),
   .rsp_file_start    (rsp.file_start),
   .rsp_file_end      (rsp.file_end),
   .rsp_truncated     (rsp.truncated),
   .rsp_declared_size (rsp.declared_size),
   .rsp_run_last      (rsp.run_last)
);
